>>> rtl/core/cifm_pkg.sv
// Shared types, constants and helpers for the collapse index forward map.
`timescale 1ns / 1ps
package cifm_pkg;

	localparam int MAX_DIMS     = 4;
	localparam int MAX_EXTENT   = 64;
	localparam int POS_W        = 25;
	localparam int EXT_W        = 7;
	localparam int VAL_W        = 7;
	localparam int TGT_W        = 3;
	localparam int CNT_W        = 3;
	localparam int DIM_W        = $clog2(MAX_DIMS);
	localparam int MARGIN_W     = $clog2(MAX_EXTENT);
	localparam int DIV_STAGES   = 5;
	localparam int DIV_STEPS    = POS_W / DIV_STAGES;
	localparam int CFG_W        = 28;
	localparam int CFG_IDX_W    = 3;
	localparam int PROD_W       = POS_W + VAL_W;
	localparam int PIPE_LATENCY = MAX_DIMS * (DIV_STAGES + 1) + 2;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_MAP   = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_COUNT   = 3'd0,
		REG_SRC_EXTENTS = 3'd1,
		REG_DIM_TARGETS = 3'd2,
		REG_TGT_COUNT   = 3'd3,
		REG_STRIDE_0    = 3'd4,
		REG_STRIDE_1    = 3'd5,
		REG_STRIDE_2    = 3'd6,
		REG_STRIDE_3    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                cmd;
		logic [POS_W-1:0]    source_position;
		logic [DIM_W-1:0]    table_dim;
		logic [MARGIN_W-1:0] table_margin;
		logic [VAL_W-1:0]    table_value;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] target_position;
		logic             excluded;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]                   src_count;
		logic [MAX_DIMS-1:0][EXT_W-1:0]     extents;
		logic [MAX_DIMS-1:0][TGT_W-1:0]     targets;
		logic [CNT_W-1:0]                   tgt_count;
		logic [MAX_DIMS-1:0][POS_W-1:0]     strides;
	} cfg_t;

	// One beat travelling down the pipe; table writes ride along with map beats.
	typedef struct packed {
		logic                           valid;
		logic                           is_map;
		logic                           excl;
		logic [POS_W-1:0]               q;
		logic [EXT_W-1:0]               rem;
		logic [MAX_DIMS-1:0][VAL_W-1:0] after;
		logic [DIM_W-1:0]               wr_dim;
		logic [MARGIN_W-1:0]            wr_margin;
		logic [VAL_W-1:0]               wr_value;
	} pipe_t;

	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
		return (c > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : c;
	endfunction

endpackage

>>> rtl/core/cifm_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
module cifm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/cifm_dim_unit.sv
// One source dimension: pipelined divide by its extent, then its index table lookup.
`timescale 1ns / 1ps
module cifm_dim_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cifm_pkg::DIM_W-1:0] dim_idx,
	input  cifm_pkg::cfg_t             cfg,
	input  cifm_pkg::pipe_t            in_p,
	output cifm_pkg::pipe_t            out_p
);

	cifm_pkg::pipe_t div_s [cifm_pkg::DIV_STAGES];
	cifm_pkg::pipe_t lk_s;
	cifm_pkg::pipe_t p0;
	cifm_pkg::pipe_t dq;
	logic                          hit_s;
	logic [cifm_pkg::EXT_W-1:0]    divisor;
	logic [cifm_pkg::CNT_W-1:0]    nsrc;
	logic [cifm_pkg::CNT_W-1:0]    ntgt;
	logic [cifm_pkg::TGT_W-1:0]    tgt;
	logic                          active;
	logic                          in_tab;
	logic                          we;
	logic [cifm_pkg::VAL_W-1:0]    rd_data;

	// Restoring division, a few quotient bits per stage; q shifts out the dividend
	// and shifts in the quotient.
	function automatic cifm_pkg::pipe_t div_steps(input cifm_pkg::pipe_t p,
			input logic [cifm_pkg::EXT_W-1:0] dv);
		cifm_pkg::pipe_t r;
		logic [cifm_pkg::EXT_W:0] t;
		r = p;
		for (int j = 0; j < cifm_pkg::DIV_STEPS; j++) begin
			t = {r.rem, r.q[cifm_pkg::POS_W-1]};
			if (t >= {1'b0, dv}) begin
				r.rem = cifm_pkg::EXT_W'(t - {1'b0, dv});
				r.q   = {r.q[cifm_pkg::POS_W-2:0], 1'b1};
			end else begin
				r.rem = t[cifm_pkg::EXT_W-1:0];
				r.q   = {r.q[cifm_pkg::POS_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	assign nsrc    = cifm_pkg::sat_count(cfg.src_count);
	assign ntgt    = cifm_pkg::sat_count(cfg.tgt_count);
	assign active  = {1'b0, dim_idx} < nsrc;
	assign divisor = (cfg.extents[dim_idx] == '0) ? cifm_pkg::EXT_W'(1) : cfg.extents[dim_idx];
	assign tgt     = cfg.targets[dim_idx];

	always_comb begin
		p0     = in_p;
		p0.rem = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cifm_pkg::DIV_STAGES; i++) begin
				div_s[i] <= '0;
			end
		end else begin
			div_s[0] <= div_steps(p0, divisor);
			for (int i = 1; i < cifm_pkg::DIV_STAGES; i++) begin
				div_s[i] <= div_steps(div_s[i-1], divisor);
			end
		end
	end

	assign dq     = div_s[cifm_pkg::DIV_STAGES-1];
	assign in_tab = dq.rem < cifm_pkg::EXT_W'(cifm_pkg::MAX_EXTENT);
	// table writes land in order with the map beats, so no forwarding is needed
	assign we     = dq.valid && !dq.is_map && (dq.wr_dim == dim_idx);

	cifm_ram #(
		.DEPTH(cifm_pkg::MAX_EXTENT),
		.WIDTH(cifm_pkg::VAL_W)
	) u_bank (
		.clk  (clk),
		.we   (we),
		.waddr(dq.wr_margin),
		.wdata(dq.wr_value),
		.raddr(dq.rem[cifm_pkg::MARGIN_W-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_s  <= '0;
			hit_s <= 1'b0;
		end else begin
			lk_s  <= dq;
			hit_s <= in_tab;
		end
	end

	always_comb begin
		out_p = lk_s;
		if (lk_s.valid && lk_s.is_map && active && !lk_s.excl) begin
			if (!hit_s || rd_data == '0) begin
				out_p.excl = 1'b1;
			end else if (tgt != '0 && tgt <= ntgt) begin
				out_p.after[cifm_pkg::DIM_W'(tgt - cifm_pkg::TGT_W'(1))] = rd_data;
			end
		end
	end

endmodule

>>> rtl/core/cifm_stride_sum.sv
// Stride multiply and sum of target margins into the result register.
`timescale 1ns / 1ps
module cifm_stride_sum (
	input  logic              clk,
	input  logic              arst_n,
	input  cifm_pkg::cfg_t    cfg,
	input  cifm_pkg::pipe_t   in_p,
	output logic              done,
	output cifm_pkg::result_t result
);

	logic [cifm_pkg::POS_W-1:0] prod_s1 [cifm_pkg::MAX_DIMS];
	logic [cifm_pkg::POS_W-1:0] prod_c  [cifm_pkg::MAX_DIMS];
	logic                       v_s1;
	logic                       excl_s1;
	logic                       done_q;
	cifm_pkg::result_t          result_q;
	logic [cifm_pkg::CNT_W-1:0] ntgt;
	logic [cifm_pkg::POS_W-1:0] sum;
	logic [cifm_pkg::PROD_W-1:0] full;

	assign ntgt = cifm_pkg::sat_count(cfg.tgt_count);

	always_comb begin
		full = '0;
		for (int k = 0; k < cifm_pkg::MAX_DIMS; k++) begin
			full = cifm_pkg::PROD_W'(cfg.strides[k]) *
				cifm_pkg::PROD_W'(in_p.after[k] - cifm_pkg::VAL_W'(1));
			prod_c[k] = (cifm_pkg::CNT_W'(k) < ntgt) ? full[cifm_pkg::POS_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_p.valid && in_p.is_map;
		end
	end

	always_ff @(posedge clk) begin
		excl_s1 <= in_p.excl;
		for (int k = 0; k < cifm_pkg::MAX_DIMS; k++) begin
			prod_s1[k] <= prod_c[k];
		end
	end

	always_comb begin
		sum = cifm_pkg::POS_W'(1);
		for (int k = 0; k < cifm_pkg::MAX_DIMS; k++) begin
			sum = sum + prod_s1[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_q.target_position <= excl_s1 ? '0 : sum;
		result_q.excluded        <= excl_s1;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/core/collapse_index_forward_map_unit.sv
// Top level of the collapse index forward map: config registers and the dimension pipeline.
`timescale 1ns / 1ps
// Takes one beat per cycle, never busy. A map beat (cmd 1) produces its result
// on result/done through the registered pipe below; the receiver cannot stall.
// The pipe holds, for each of four dimensions, five divider stages of five
// quotient bits each plus one table read stage, then a multiply stage and a
// sum stage. Table write beats (cmd 0) travel the same pipe and update the
// table bank of the dimension named by table_dim, in order with map beats;
// they give no result. Index tables are not cleared at reset.
module collapse_index_forward_map_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  cifm_pkg::item_t                item,
	output logic                           done,
	output cifm_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cifm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cifm_pkg::CFG_W-1:0]     cfg_data
);

	cifm_pkg::cfg_t  cfg_q;
	cifm_pkg::pipe_t link [cifm_pkg::MAX_DIMS+1];
	logic            accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_count <= cifm_pkg::CNT_W'(1);
			cfg_q.tgt_count <= cifm_pkg::CNT_W'(1);
			cfg_q.targets   <= '0;
			for (int k = 0; k < cifm_pkg::MAX_DIMS; k++) begin
				cfg_q.extents[k] <= cifm_pkg::EXT_W'(1);
				cfg_q.strides[k] <= cifm_pkg::POS_W'(1);
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cifm_pkg::cfg_reg_t'(cfg_index))
				cifm_pkg::REG_SRC_COUNT:   cfg_q.src_count  <= cfg_data[cifm_pkg::CNT_W-1:0];
				cifm_pkg::REG_SRC_EXTENTS: cfg_q.extents    <= cfg_data;
				cifm_pkg::REG_DIM_TARGETS: cfg_q.targets    <= cfg_data[11:0];
				cifm_pkg::REG_TGT_COUNT:   cfg_q.tgt_count  <= cfg_data[cifm_pkg::CNT_W-1:0];
				cifm_pkg::REG_STRIDE_0:    cfg_q.strides[0] <= cfg_data[cifm_pkg::POS_W-1:0];
				cifm_pkg::REG_STRIDE_1:    cfg_q.strides[1] <= cfg_data[cifm_pkg::POS_W-1:0];
				cifm_pkg::REG_STRIDE_2:    cfg_q.strides[2] <= cfg_data[cifm_pkg::POS_W-1:0];
				cifm_pkg::REG_STRIDE_3:    cfg_q.strides[3] <= cfg_data[cifm_pkg::POS_W-1:0];
			endcase
		end
	end

	always_comb begin
		link[0].valid     = accept;
		link[0].is_map    = (item.cmd == cifm_pkg::CMD_MAP);
		link[0].excl      = 1'b0;
		link[0].q         = item.source_position - cifm_pkg::POS_W'(1);
		link[0].rem       = '0;
		link[0].wr_dim    = item.table_dim;
		link[0].wr_margin = item.table_margin;
		link[0].wr_value  = item.table_value;
		for (int k = 0; k < cifm_pkg::MAX_DIMS; k++) begin
			link[0].after[k] = cifm_pkg::VAL_W'(1);
		end
	end

	for (genvar g = 0; g < cifm_pkg::MAX_DIMS; g++) begin : g_dim
		cifm_dim_unit u_dim (
			.clk    (clk),
			.arst_n (arst_n),
			.dim_idx(cifm_pkg::DIM_W'(g)),
			.cfg    (cfg_q),
			.in_p   (link[g]),
			.out_p  (link[g+1])
		);
	end

	cifm_stride_sum u_sum (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.in_p  (link[cifm_pkg::MAX_DIMS]),
		.done  (done),
		.result(result)
	);

	a_map_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.cmd == cifm_pkg::CMD_MAP |-> ##(cifm_pkg::PIPE_LATENCY) done)
		else $error("map beat produced no result");

	a_result_has_map: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept && item.cmd == cifm_pkg::CMD_MAP, cifm_pkg::PIPE_LATENCY))
		else $error("result without a map beat");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.cmd == cifm_pkg::CMD_WRITE |-> ##(cifm_pkg::PIPE_LATENCY) !done)
		else $error("table write beat produced a result");

	a_excluded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.excluded |-> result.target_position == '0)
		else $error("excluded result with nonzero position");

endmodule
